/* design/bb3_pkg.sv */
// Package for the 3x3 box blur stream: payload structs, size constants and
// the pipeline control struct. Depends on nothing; used by box_blur_3x3_stream_top.
`default_nettype none

package bb3_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    // Column counter and line store address width.
    localparam int COL_W  = $clog2(MAX_WIDTH);
    // Output field widths fixed by the interface.
    localparam int FCOL_W = 10;
    localparam int FROW_W = 10;
    // Register width of the frame size registers.
    localparam int SIZE_W = 11;
    // Row counters saturate at ROW_CAP.
    localparam int ROW_W  = 13;
    localparam logic [ROW_W-1:0] ROW_CAP = {ROW_W{1'b1}};

    localparam logic [SIZE_W-1:0] MAX_W_SZ = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] MAX_H_SZ = SIZE_W'(MAX_HEIGHT);
    localparam logic [SIZE_W-1:0] WIDTH_RST  = SIZE_W'(1000);
    localparam logic [SIZE_W-1:0] HEIGHT_RST = SIZE_W'(700);

    // Channel sums reach 9 * 255, which fits in 12 bits. Division by nine is a
    // multiplication by ceil(2^16 / 9) and a shift by 16, exact for such sums.
    localparam int SUM_W = 12;
    localparam logic [12:0] RECIP9 = 13'd7282;
    localparam int RECIP_SH = 16;
    localparam int PROD_W = SUM_W + 13;

    localparam int RGB_W = 24;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // Configuration register indexes (paddr[2]).
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [31:0] pixel_word;
    } t_blur_in;

    typedef struct packed {
        logic [31:0]       out_pixel;
        logic [FCOL_W-1:0] out_col;
        logic [FROW_W-1:0] out_row;
        logic              frame_last;
    } t_blur_out;

    // Per-item control that follows the pixel down the pipeline.
    typedef struct packed {
        logic              emit;
        logic              use_left;
        logic              use_right;
        logic              use_top;
        logic              use_bot;
        logic [FCOL_W-1:0] col;
        logic [FROW_W-1:0] row;
        logic              last;
    } t_ctrl;

endpackage

`default_nettype wire

/* design/box_blur_3x3_stream_top.sv */
// Streaming 3x3 box blur: line stores, window, adder tree and divide by nine.
// Depends on bb3_pkg.
`default_nettype none

// Usage:
// Pixel items enter on the input channel (i_in_valid / o_in_ready, payload
// t_blur_in) in raster order, one per clock when the output side keeps up.
// Each result item leaves on the output channel (o_out_valid / i_out_ready,
// payload t_blur_out) in raster order with its column, row and a flag on the
// frame's final pixel. A result needs the pixel one row and one column below
// it, so results trail the input by frame_width + 1 items; after the last
// pixel, frame_width + 1 flush items (cmd = 1) drain the tail. Flush items sent
// before all pixels are in are accepted and dropped.
// The item completing a window passes store read, window shift, sums and divide.
// Throughput is one item per cycle while the receiver keeps up; the line store
// ports, one read and one write each per cycle, set that figure. Back-to-back
// accesses to the same line store entry (frame width one) are served by forwarding.
// The whole pipeline advances together: when a result waits and the receiver
// holds i_out_ready low, o_in_ready goes low until the result is taken.
// Frame width and height are set through the APB-style port (offsets 0 and 4) by
// the user only while the block is idle; the block itself does not enforce this.
// Synchronous reset clears the counters, pipeline and window and restores the
// size registers to 1000 x 700; line store content is left as is and is never
// used before it is written in a frame.
module box_blur_3x3_stream_top (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire bb3_pkg::t_blur_in i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output bb3_pkg::t_blur_out  o_out_data,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire  [2:0]          paddr,
    input  wire  [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import bb3_pkg::*;

    // Configuration registers.
    logic [SIZE_W-1:0] r_frame_width;
    logic [SIZE_W-1:0] r_frame_height;
    logic [SIZE_W-1:0] w_eff;
    logic [SIZE_W-1:0] h_eff;

    // Position counters.
    logic [COL_W-1:0] r_in_col,  n_in_col;
    logic [ROW_W-1:0] r_in_row,  n_in_row;
    logic [COL_W-1:0] r_out_col, n_out_col;
    logic [ROW_W-1:0] r_out_row, n_out_row;

    // Line stores.
    logic [RGB_W-1:0] upper_mem [MAX_WIDTH];
    logic [RGB_W-1:0] lower_mem [MAX_WIDTH];
    logic [RGB_W-1:0] r_rd_upper;
    logic [RGB_W-1:0] r_rd_lower;

    // Stage 1: line store read in flight.
    logic             r_s1_valid;
    logic             r_s1_wr;
    logic [COL_W-1:0] r_s1_addr;
    logic [RGB_W-1:0] r_s1_bot;
    logic             r_s1_fwd;
    logic [RGB_W-1:0] r_s1_fwd_upper;
    logic [RGB_W-1:0] r_s1_fwd_lower;
    t_ctrl            r_s1_ctrl;
    logic [RGB_W-1:0] s1_top;
    logic [RGB_W-1:0] s1_mid;

    // Window, three columns of three rows; index column * 3 + row.
    logic [RGB_W-1:0] r_win [9];

    // Stage 2: window holds this item's neighborhood.
    logic  r_s2_valid;
    t_ctrl r_s2_ctrl;

    // Stage 3: channel sums.
    logic             r_s3_valid;
    t_ctrl            r_s3_ctrl;
    logic [SUM_W-1:0] r_sum_r, r_sum_g, r_sum_b;
    logic [SUM_W-1:0] n_sum_r, n_sum_g, n_sum_b;

    // Output register.
    logic      r_out_valid;
    t_blur_out r_out_data;

    // Accept-side decode.
    logic             adv;
    logic             accept;
    logic             input_done;
    logic             enter;
    logic             emit;
    logic             last;
    logic [RGB_W-1:0] in_rgb;
    t_ctrl            n_ctrl;
    logic [PROD_W-1:0] prod_r, prod_g, prod_b;

    // Sizes outside 1..MAX are clamped.
    always_comb begin
        if (r_frame_width == '0) begin
            w_eff = SIZE_W'(1);
        end else if (r_frame_width > MAX_W_SZ) begin
            w_eff = MAX_W_SZ;
        end else begin
            w_eff = r_frame_width;
        end
        if (r_frame_height == '0) begin
            h_eff = SIZE_W'(1);
        end else if (r_frame_height > MAX_H_SZ) begin
            h_eff = MAX_H_SZ;
        end else begin
            h_eff = r_frame_height;
        end
    end

    // Configuration port.
    assign pready = 1'b1;
    always_comb begin
        case (paddr[2])
            REG_WIDTH:  prdata = {{(32-SIZE_W){1'b0}}, r_frame_width};
            REG_HEIGHT: prdata = {{(32-SIZE_W){1'b0}}, r_frame_height};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= WIDTH_RST;
            r_frame_height <= HEIGHT_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_WIDTH:  r_frame_width  <= pwdata[SIZE_W-1:0];
                REG_HEIGHT: r_frame_height <= pwdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // The whole pipeline moves when the output register is free or being taken.
    assign adv        = !r_out_valid || i_out_ready;
    assign o_in_ready = adv;
    assign accept     = i_in_valid && adv;

    assign input_done = (r_in_row >= {{(ROW_W-SIZE_W){1'b0}}, h_eff});
    // A flush before the frame's pixels are all in changes nothing.
    assign enter  = accept && !(i_in_data.cmd == CMD_FLUSH && !input_done);
    assign in_rgb = i_in_data.pixel_word[31:8];

    // The first row and one pixel of the next produce no result.
    assign emit = !(((r_in_row == '0) && ({1'b0, r_in_col} <= w_eff))
                    || ((r_in_row == ROW_W'(1)) && (r_in_col == '0)));
    assign last = emit
                  && (({1'b0, r_out_row} + 14'd1) >= {3'b000, h_eff})
                  && (({1'b0, r_out_col} + 11'd1) >= w_eff);

    // Counter update and per-item control for an item that enters.
    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (({1'b0, r_in_col} + 11'd1) >= w_eff) begin
            n_in_col = '0;
            if (r_in_row != ROW_CAP) begin
                n_in_row = r_in_row + ROW_W'(1);
            end
        end else begin
            n_in_col = r_in_col + COL_W'(1);
        end
        if (last) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end else if (emit) begin
            if (({1'b0, r_out_col} + 11'd1) >= w_eff) begin
                n_out_col = '0;
                if (r_out_row != ROW_CAP) begin
                    n_out_row = r_out_row + ROW_W'(1);
                end
            end else begin
                n_out_col = r_out_col + COL_W'(1);
            end
        end

        n_ctrl.emit      = emit;
        n_ctrl.use_left  = (r_out_col != '0);
        n_ctrl.use_right = (({1'b0, r_out_col} + 11'd1) < w_eff);
        n_ctrl.use_top   = (r_out_row != '0);
        n_ctrl.use_bot   = (({1'b0, r_out_row} + 14'd1) < {3'b000, h_eff});
        n_ctrl.col       = r_out_col[FCOL_W-1:0];
        n_ctrl.row       = r_out_row[FROW_W-1:0];
        n_ctrl.last      = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (enter) begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    // Stage 1 data: forwarded values win over the store when the previous item
    // wrote the same entry in the cycle this read was issued.
    assign s1_top = r_s1_fwd ? r_s1_fwd_upper : r_rd_upper;
    assign s1_mid = r_s1_fwd ? r_s1_fwd_lower : r_rd_lower;

    // Line stores: read at the accept edge, rotate when the pipeline next advances.
    always_ff @(posedge i_clk) begin
        if (enter) begin
            r_rd_upper <= upper_mem[r_in_col];
            r_rd_lower <= lower_mem[r_in_col];
        end
        if (adv && r_s1_valid && r_s1_wr) begin
            upper_mem[r_s1_addr] <= s1_mid;
            lower_mem[r_s1_addr] <= r_s1_bot;
        end
    end

    // Stage 1 registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= enter;
        end
        if (adv) begin
            r_s1_wr        <= !input_done;
            r_s1_addr      <= r_in_col;
            r_s1_bot       <= input_done ? '0 : in_rgb;
            r_s1_fwd       <= r_s1_valid && r_s1_wr && (r_s1_addr == r_in_col);
            r_s1_fwd_upper <= s1_mid;
            r_s1_fwd_lower <= r_s1_bot;
            r_s1_ctrl      <= n_ctrl;
        end
    end

    // Window shift: the oldest column drops out, the new column enters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else if (adv && r_s1_valid) begin
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= r_win[k+3];
            end
            r_win[6] <= s1_top;
            r_win[7] <= s1_mid;
            r_win[8] <= r_s1_bot;
        end
    end

    // Stage 2 control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s2_valid <= r_s1_valid && r_s1_ctrl.emit;
        end
        if (adv) begin
            r_s2_ctrl <= r_s1_ctrl;
        end
    end

    // Masked channel sums over the window; taps outside the frame count zero.
    always_comb begin
        logic col_on;
        logic row_on;
        n_sum_r = '0;
        n_sum_g = '0;
        n_sum_b = '0;
        for (int dc = 0; dc < 3; dc++) begin
            for (int dr = 0; dr < 3; dr++) begin
                col_on = !((dc == 0 && !r_s2_ctrl.use_left)
                           || (dc == 2 && !r_s2_ctrl.use_right));
                row_on = !((dr == 0 && !r_s2_ctrl.use_top)
                           || (dr == 2 && !r_s2_ctrl.use_bot));
                if (col_on && row_on) begin
                    n_sum_r = n_sum_r + SUM_W'(r_win[dc*3+dr][23:16]);
                    n_sum_g = n_sum_g + SUM_W'(r_win[dc*3+dr][15:8]);
                    n_sum_b = n_sum_b + SUM_W'(r_win[dc*3+dr][7:0]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (adv) begin
            r_s3_valid <= r_s2_valid;
        end
        if (adv) begin
            r_s3_ctrl <= r_s2_ctrl;
            r_sum_r   <= n_sum_r;
            r_sum_g   <= n_sum_g;
            r_sum_b   <= n_sum_b;
        end
    end

    // Divide by nine through the reciprocal.
    assign prod_r = PROD_W'(r_sum_r) * PROD_W'(RECIP9);
    assign prod_g = PROD_W'(r_sum_g) * PROD_W'(RECIP9);
    assign prod_b = PROD_W'(r_sum_b) * PROD_W'(RECIP9);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_s3_valid;
        end
        if (adv) begin
            r_out_data.out_pixel  <= {prod_r[RECIP_SH+7:RECIP_SH],
                                      prod_g[RECIP_SH+7:RECIP_SH],
                                      prod_b[RECIP_SH+7:RECIP_SH],
                                      ALPHA_OPAQUE};
            r_out_data.out_col    <= r_s3_ctrl.col;
            r_out_data.out_row    <= r_s3_ctrl.row;
            r_out_data.frame_last <= r_s3_ctrl.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire
